// File: rtl/core/sref_pkg.sv
// Shared types and constants for the segment RMS envelope follower.
package sref_pkg;

   localparam int SumWidth   = 59;
   localparam int SampWidth  = 24;
   localparam int RawWidth   = 20;
   localparam int LvlWidth   = 17;
   localparam int LenWidth   = 13;
   localparam int GainWidth  = 16;
   localparam int CntWidth   = 14;
   localparam int RootWidth  = 30;
   localparam int Bands      = 16;
   localparam int BandBits   = 4;

   localparam logic [SumWidth-1:0] SumMax   = {SumWidth{1'b1}};
   localparam logic [RawWidth-1:0] RawMax   = {RawWidth{1'b1}};
   localparam logic [LvlWidth-1:0] OneQ16   = 17'h10000;

   localparam logic [2:0] CsrBufferLength = 3'd0;
   localparam logic [2:0] CsrChannelCount = 3'd1;
   localparam logic [2:0] CsrHeightGain   = 3'd2;
   localparam logic [2:0] CsrAttackCoeff  = 3'd3;
   localparam logic [2:0] CsrReleaseCoeff = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_SQRT,
      ST_GAIN,
      ST_SMOOTH,
      ST_OUT
   } state_type;

endpackage

// File: rtl/core/segment_rms_envelope_follower_unit.sv
// Segment RMS envelope follower top level: frame accumulation, segment control and CSRs.
// One frame is taken per transfer; squares of both channels come from parallel lanes
// and add into a saturating 59-bit sum. A frame that closes no segment only adds into
// the sum; the next frame may follow at once unless it was the buffer's last. A closed
// segment goes through a bit-serial divider, a bit-serial square root, a gain state and
// a smoothing state; a frame that closes a segment holds off input until the level unit
// is idle and its result taken. The buffer's last frame reports all remaining segments
// one after another, up to 16 results. Input is held off while results are being formed.
module segment_rms_envelope_follower_unit
   import sref_pkg::*;
#(
   parameter int MAX_BUFFER = 4096,
   parameter int CHANNELS   = 2
)
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_write,
   input  logic [2:0]                  csr_index,
   input  logic [LvlWidth-1:0]         csr_data,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [SampWidth-1:0] req_sample_0,
   input  logic signed [SampWidth-1:0] req_sample_1,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [3:0]                  rsp_band_index,
   output logic [RawWidth-1:0]         rsp_raw_level,
   output logic [LvlWidth-1:0]         rsp_smoothed_level,
   output logic                        rsp_last_band
);

   localparam int BW = BandBits;
   localparam int CB = $clog2(Bands + 1);
   localparam int ChLim = (CHANNELS < 2) ? CHANNELS : 2;

   logic [LenWidth-1:0]  buf_len_ff;
   logic [1:0]           chan_ff;
   logic [GainWidth-1:0] gain_ff;
   logic [LvlWidth-1:0]  attack_ff, release_ff;

   logic [SumWidth-1:0]  sum_ff, sum_in;
   logic [LenWidth-1:0]  pos_ff, pos_in;
   logic [CB-1:0]        band_ff, band_in;
   logic [LenWidth-1:0]  fib_ff, fib_in;
   logic                 flush_ff, flush_in;
   logic [1:0]           ch_eff;

   logic [LenWidth-1:0]  len, spb;
   logic [2*SampWidth-1:0] sq0, sq1;
   logic [SumWidth-1:0]  sq, sum_add;
   logic [SumWidth:0]    sum_wide;
   logic                 take, busy, start;
   logic [SumWidth-1:0]  st_sum;
   logic [LenWidth-1:0]  st_frames;
   logic [CntWidth-1:0]  st_count;

   always_comb begin
      if (buf_len_ff == '0) len = LenWidth'(1);
      else if (32'(buf_len_ff) > MAX_BUFFER) len = LenWidth'(MAX_BUFFER);
      else len = buf_len_ff;
      spb = LenWidth'(len / Bands);
      if (spb == '0) spb = LenWidth'(1);
      if (chan_ff == 2'd0) ch_eff = 2'd1;
      else if (32'(chan_ff) > ChLim) ch_eff = 2'(ChLim);
      else ch_eff = chan_ff;
   end

   sref_lane u_lane0 (
      .enable (1'b1),
      .sample (req_sample_0),
      .square (sq0)
   );

   sref_lane u_lane1 (
      .enable (ch_eff == 2'd2),
      .sample (req_sample_1),
      .square (sq1)
   );

   assign sq       = SumWidth'(sq0) + SumWidth'(sq1);
   assign sum_wide = {1'b0, sum_ff} + {1'b0, sq};
   assign sum_add  = sum_wide[SumWidth] ? SumMax : sum_wide[SumWidth-1:0];

   assign req_stall = busy || flush_ff || rsp_valid;
   assign take      = req_valid && !req_stall;

   always_comb begin
      sum_in    = sum_ff;
      pos_in    = pos_ff;
      band_in   = band_ff;
      fib_in    = fib_ff;
      flush_in  = flush_ff;
      start     = 1'b0;
      st_sum    = sum_ff;
      st_frames = fib_ff;
      if (take) begin
         if (32'(band_ff) < Bands) begin
            st_sum    = sum_add;
            st_frames = fib_ff + LenWidth'(1);
            if (st_frames >= spb) begin
               start   = 1'b1;
               sum_in  = '0;
               fib_in  = '0;
               band_in = band_ff + CB'(1);
            end else begin
               sum_in = sum_add;
               fib_in = st_frames;
            end
         end
         if (pos_ff >= len - LenWidth'(1)) begin
            flush_in = 1'b1;
            pos_in   = '0;
         end else begin
            pos_in = pos_ff + LenWidth'(1);
         end
      end else if (flush_ff && !busy && !start) begin
         if (32'(band_ff) < Bands) begin
            start   = 1'b1;
            sum_in  = '0;
            fib_in  = '0;
            band_in = band_ff + CB'(1);
         end else begin
            flush_in = 1'b0;
            band_in  = '0;
            sum_in   = '0;
            fib_in   = '0;
         end
      end
   end

   assign st_count = CntWidth'(st_frames) * CntWidth'(ch_eff);

   sref_level u_level (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .band               (band_ff[BW-1:0]),
      .sum                (st_sum),
      .count              (st_count),
      .gain               (gain_ff),
      .attack             (attack_ff),
      .release_c          (release_ff),
      .busy               (busy),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_band_index     (rsp_band_index),
      .rsp_raw_level      (rsp_raw_level),
      .rsp_smoothed_level (rsp_smoothed_level),
      .rsp_last_band      (rsp_last_band)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff <= LenWidth'(512);
         chan_ff    <= 2'd2;
         gain_ff    <= GainWidth'(4096);
         attack_ff  <= LvlWidth'(52429);
         release_ff <= LvlWidth'(32768);
         sum_ff     <= '0;
         pos_ff     <= '0;
         band_ff    <= '0;
         fib_ff     <= '0;
         flush_ff   <= 1'b0;
      end else begin
         sum_ff   <= sum_in;
         pos_ff   <= pos_in;
         band_ff  <= band_in;
         fib_ff   <= fib_in;
         flush_ff <= flush_in;
         if (csr_write) begin
            case (csr_index)
               CsrBufferLength: buf_len_ff <= csr_data[LenWidth-1:0];
               CsrChannelCount: chan_ff    <= csr_data[1:0];
               CsrHeightGain:   gain_ff    <= csr_data[GainWidth-1:0];
               CsrAttackCoeff:  attack_ff  <= csr_data;
               CsrReleaseCoeff: release_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// File: rtl/core/sref_lane.sv
// One squaring lane: square of a single channel sample, gated by enable.
module sref_lane
   import sref_pkg::*;
(
   input  logic                        enable,
   input  logic signed [SampWidth-1:0] sample,
   output logic [2*SampWidth-1:0]      square
);

   logic signed [2*SampWidth-1:0] prod;

   assign prod   = sample * sample;
   assign square = enable ? prod : '0;

endmodule

// File: rtl/core/sref_level.sv
// Per-segment level unit: divide, square root, gain and smoothing, then output register.
module sref_level
   import sref_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [BandBits-1:0]  band,
   input  logic [SumWidth-1:0]  sum,
   input  logic [CntWidth-1:0]  count,
   input  logic [GainWidth-1:0] gain,
   input  logic [LvlWidth-1:0]  attack,
   input  logic [LvlWidth-1:0]  release_c,
   output logic                 busy,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [3:0]           rsp_band_index,
   output logic [RawWidth-1:0]  rsp_raw_level,
   output logic [LvlWidth-1:0]  rsp_smoothed_level,
   output logic                 rsp_last_band
);

   state_type state_ff, state_in;
   logic [SumWidth-1:0]  num_ff, num_in;
   logic [SumWidth-1:0]  rem_ff, rem_in;
   logic [CntWidth-1:0]  den_ff, den_in;
   logic [5:0]           step_ff, step_in;
   logic [RootWidth-1:0] root_ff, root_in;
   logic [RootWidth+1:0] srem_ff, srem_in;
   logic [RawWidth-1:0]  raw_ff, raw_in;
   logic [BandBits-1:0]  band_ff, band_in;
   logic                 empty_ff, empty_in;
   logic [LvlWidth-1:0]  lvl_ff [Bands];
   logic                 lvl_we;
   logic [LvlWidth-1:0]  lvl_new;
   logic [LvlWidth-1:0]  old_lvl;
   logic                 valid_ff, valid_in;
   logic [LvlWidth-1:0]  out_lvl_ff;

   logic [SumWidth:0]    rem_sh;
   logic [SumWidth:0]    num_ext;
   logic [RootWidth+3:0] trial, srem_sh;
   logic [RootWidth+GainWidth-1:0] gprod;
   logic [LvlWidth-1:0]  coef;
   logic [35:0]          acc;

   assign old_lvl = lvl_ff[band_ff];
   assign rem_sh  = {rem_ff, num_ff[SumWidth-1]};
   assign num_ext = {1'b0, num_ff};
   assign srem_sh = {srem_ff, num_ext[2*step_ff[4:0]+1 -: 2]};
   assign trial   = {2'b0, root_ff, 2'b01};
   assign gprod   = root_ff * gain;

   always_comb begin
      coef = ({3'b0, raw_ff} > {{3{1'b0}}, old_lvl}) ? attack : release_c;
      if (coef > OneQ16) coef = OneQ16;
      acc = 36'(old_lvl) * 36'(coef) + 36'(raw_ff) * 36'(OneQ16 - coef) + 36'd32768;
      acc = acc >> 16;
      lvl_new = (acc > 36'(OneQ16)) ? OneQ16 : acc[LvlWidth-1:0];
   end

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      step_in  = step_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      raw_in   = raw_ff;
      band_in  = band_ff;
      empty_in = empty_ff;
      valid_in = valid_ff;
      lvl_we   = 1'b0;
      if (valid_ff && !rsp_stall) valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               num_in   = sum;
               rem_in   = '0;
               den_in   = count;
               band_in  = band;
               empty_in = (count == '0);
               step_in  = 6'(SumWidth - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_sh >= {{(SumWidth+1-CntWidth){1'b0}}, den_ff}) begin
               rem_in = SumWidth'(rem_sh - {{(SumWidth+1-CntWidth){1'b0}}, den_ff});
               num_in = {num_ff[SumWidth-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[SumWidth-1:0];
               num_in = {num_ff[SumWidth-2:0], 1'b0};
            end
            if (step_ff == '0) begin
               root_in  = '0;
               srem_in  = '0;
               step_in  = 6'(RootWidth - 1);
               state_in = ST_SQRT;
            end else begin
               step_in = step_ff - 6'd1;
            end
         end
         ST_SQRT: begin
            if (srem_sh >= trial) begin
               srem_in = (RootWidth+2)'(srem_sh - trial);
               root_in = {root_ff[RootWidth-2:0], 1'b1};
            end else begin
               srem_in = srem_sh[RootWidth+1:0];
               root_in = {root_ff[RootWidth-2:0], 1'b0};
            end
            if (step_ff == '0) state_in = ST_GAIN;
            else step_in = step_ff - 6'd1;
         end
         ST_GAIN: begin
            if (empty_ff) raw_in = '0;
            else if (gprod[RootWidth+GainWidth-1:19+RawWidth] != '0) raw_in = RawMax;
            else raw_in = gprod[19 +: RawWidth];
            state_in = ST_SMOOTH;
         end
         ST_SMOOTH: begin
            if (!valid_ff || !rsp_stall) begin
               lvl_we   = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         for (int i = 0; i < Bands; i++) lvl_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         if (lvl_we) lvl_ff[band_ff] <= lvl_new;
      end
   end

   always_ff @(posedge clock) begin
      num_ff   <= num_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      step_ff  <= step_in;
      root_ff  <= root_in;
      srem_ff  <= srem_in;
      raw_ff   <= raw_in;
      band_ff  <= band_in;
      empty_ff <= empty_in;
      if (lvl_we) begin
         out_lvl_ff     <= lvl_new;
         rsp_raw_level  <= raw_ff;
         rsp_band_index <= 4'(band_ff);
         rsp_last_band  <= (band_ff == BandBits'(Bands - 1));
      end
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_smoothed_level = out_lvl_ff;

endmodule
